// File: rtl/oa4_pkg.sv
package oa4_pkg;

    // item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    // option type, capability code and AS4 capability length values
    localparam logic [7:0] OPT_CAPABILITY = 8'd2;
    localparam logic [7:0] CAP_AS4        = 8'd65;
    localparam logic [7:0] CAP_AS4_LEN    = 8'd4;

    // byte counter saturation point
    localparam logic [8:0] BYTES_SAT = 9'd256;

    typedef enum logic [3:0] {
        PH_OPT_TYPE = 4'd0,
        PH_OPT_LEN  = 4'd1,
        PH_OPT_SKIP = 4'd2,
        PH_CAP_CODE = 4'd3,
        PH_CAP_LEN  = 4'd4,
        PH_CAP_SKIP = 4'd5,
        PH_AS_BYTES = 4'd6,
        PH_ENDED    = 4'd7
    } phase_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [31:0] as_number;
        logic        found;
    } out_item_t;

endpackage

// File: rtl/open_option_as4_capability_scan.sv
// an item marked last loads the input register at its accepting edge, then steps the
// scan into the result register once that register is free or being drained
// throughput: one item per cycle; the input stalls only while a last item waits on
// an occupied result register that is not being drained
// reset: aresetn low at a clock edge empties both registers and restarts the scan
module open_option_as4_capability_scan (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  oa4_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output oa4_pkg::out_item_t  m_item
);
    import oa4_pkg::*;

    // input register
    logic      in_valid_reg, in_valid_next;
    in_item_t  in_item_reg, in_item_next;

    // result register
    logic      m_valid_reg, m_valid_next;
    out_item_t m_item_reg, m_item_next;

    logic      advance;
    out_item_t step_result;

    // the held item steps the scan unless it carries a result and the
    // result register is occupied and not being drained
    assign advance = in_valid_reg &&
                     (!in_item_reg.last || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
            if (s_valid) begin
                in_item_next = s_item;
            end
        end
    end

    // per-byte option and capability parse
    oa4_scan u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_valid  (advance),
        .step_item   (in_item_reg),
        .step_result (step_result)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        // only items marked last produce a result
        if (advance && in_item_reg.last) begin
            m_valid_next = 1'b1;
            m_item_next  = step_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        in_item_reg <= in_item_next;
        m_item_reg  <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // a result without a found capability carries a zero AS number
    a_zero_when_missing: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_item_reg.found) |-> m_item_reg.as_number == 32'd0)
        else $error("nonzero as number without found");

    // a last item that steps the scan always lands in the result register
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_item_reg.last) |=> m_valid_reg)
        else $error("last item lost its result");

    // backpressure toward the source only when a held last item waits on an occupied, undrained result register
    a_ready_low_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && in_item_reg.last && m_valid_reg && !m_ready))
        else $error("input stalled without cause");

endmodule

// File: rtl/oa4_scan.sv
module oa4_scan (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_valid,
    input  oa4_pkg::in_item_t   step_item,
    output oa4_pkg::out_item_t  step_result
);
    import oa4_pkg::*;

    logic [7:0]  area_length_reg, area_length_next;
    logic [8:0]  bytes_seen_reg, bytes_seen_next;
    phase_t      phase_reg, phase_next;
    logic [8:0]  option_end_reg, option_end_next;
    logic [8:0]  capability_end_reg, capability_end_next;
    logic [7:0]  skip_remaining_reg, skip_remaining_next;
    logic [7:0]  held_type_reg, held_type_next;
    logic [31:0] as_acc_reg, as_acc_next;
    logic        as_done_reg, as_done_next;

    phase_t      ph;
    logic [7:0]  b;
    logic [9:0]  p_plus2;
    logic [9:0]  p_plus1_b;
    logic [9:0]  area_ext;
    logic [9:0]  opt_end_ext;
    logic [7:0]  skip_dec;
    logic        result_ok;

    assign b           = step_item.value;
    assign p_plus2     = {1'b0, bytes_seen_reg} + 10'd2;
    assign p_plus1_b   = {1'b0, bytes_seen_reg} + 10'd1 + {2'b00, b};
    assign area_ext    = {2'b00, area_length_reg};
    assign opt_end_ext = {1'b0, option_end_reg};
    assign skip_dec    = skip_remaining_reg - 8'd1;

    // effective phase after the end-of-option and end-of-area checks
    always_comb begin
        ph = phase_reg;
        if (ph == PH_CAP_CODE && bytes_seen_reg >= option_end_reg) begin
            ph = PH_OPT_TYPE;
        end
        if (ph == PH_OPT_TYPE && bytes_seen_reg >= {1'b0, area_length_reg}) begin
            ph = PH_ENDED;
        end
    end

    always_comb begin
        area_length_next    = area_length_reg;
        bytes_seen_next     = bytes_seen_reg;
        phase_next          = phase_reg;
        option_end_next     = option_end_reg;
        capability_end_next = capability_end_reg;
        skip_remaining_next = skip_remaining_reg;
        held_type_next      = held_type_reg;
        as_acc_next         = as_acc_reg;
        as_done_next        = as_done_reg;

        if (step_valid) begin
            if (step_item.kind == KIND_START) begin
                area_length_next    = b;
                bytes_seen_next     = '0;
                phase_next          = PH_OPT_TYPE;
                option_end_next     = '0;
                capability_end_next = '0;
                skip_remaining_next = '0;
                held_type_next      = '0;
                as_acc_next         = '0;
                as_done_next        = 1'b0;
            end else begin
                phase_next = ph;
                unique case (ph)
                    PH_OPT_TYPE: begin
                        if (p_plus2 > area_ext) begin
                            phase_next = PH_ENDED;
                        end else begin
                            held_type_next = b;
                            phase_next     = PH_OPT_LEN;
                        end
                    end
                    PH_OPT_LEN: begin
                        if (p_plus1_b > area_ext) begin
                            phase_next = PH_ENDED;
                        end else begin
                            option_end_next = p_plus1_b[8:0];
                            if (held_type_reg == OPT_CAPABILITY) begin
                                phase_next = PH_CAP_CODE;
                            end else if (b == 8'd0) begin
                                phase_next = PH_OPT_TYPE;
                            end else begin
                                skip_remaining_next = b;
                                phase_next          = PH_OPT_SKIP;
                            end
                        end
                    end
                    PH_OPT_SKIP: begin
                        skip_remaining_next = skip_dec;
                        if (skip_dec == 8'd0) begin
                            phase_next = PH_OPT_TYPE;
                        end
                    end
                    PH_CAP_CODE: begin
                        if (p_plus2 > opt_end_ext) begin
                            phase_next = PH_ENDED;
                        end else begin
                            held_type_next = b;
                            phase_next     = PH_CAP_LEN;
                        end
                    end
                    PH_CAP_LEN: begin
                        if (p_plus1_b > opt_end_ext) begin
                            phase_next = PH_ENDED;
                        end else if (held_type_reg == CAP_AS4) begin
                            if (b != CAP_AS4_LEN) begin
                                phase_next = PH_ENDED;
                            end else begin
                                as_acc_next         = '0;
                                skip_remaining_next = CAP_AS4_LEN;
                                phase_next          = PH_AS_BYTES;
                            end
                        end else if (b == 8'd0) begin
                            phase_next = PH_CAP_CODE;
                        end else begin
                            capability_end_next = p_plus1_b[8:0];
                            phase_next          = PH_CAP_SKIP;
                        end
                    end
                    PH_CAP_SKIP: begin
                        if (({1'b0, bytes_seen_reg} + 10'd1) >=
                            {1'b0, capability_end_reg}) begin
                            phase_next = PH_CAP_CODE;
                        end
                    end
                    PH_AS_BYTES: begin
                        as_acc_next         = {as_acc_reg[23:0], b};
                        skip_remaining_next = skip_dec;
                        if (skip_dec == 8'd0) begin
                            as_done_next = 1'b1;
                            phase_next   = PH_ENDED;
                        end
                    end
                    default: begin
                        phase_next = PH_ENDED;
                    end
                endcase

                if (bytes_seen_reg != BYTES_SAT) begin
                    bytes_seen_next = bytes_seen_reg + 9'd1;
                end
            end
        end
    end

    // result as seen after this item's update
    assign result_ok = (bytes_seen_next >= {1'b0, area_length_next}) && as_done_next;

    always_comb begin
        step_result.found     = result_ok;
        step_result.as_number = result_ok ? as_acc_next : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            area_length_reg    <= '0;
            bytes_seen_reg     <= '0;
            phase_reg          <= PH_OPT_TYPE;
            option_end_reg     <= '0;
            capability_end_reg <= '0;
            skip_remaining_reg <= '0;
            held_type_reg      <= '0;
            as_acc_reg         <= '0;
            as_done_reg        <= 1'b0;
        end else begin
            area_length_reg    <= area_length_next;
            bytes_seen_reg     <= bytes_seen_next;
            phase_reg          <= phase_next;
            option_end_reg     <= option_end_next;
            capability_end_reg <= capability_end_next;
            skip_remaining_reg <= skip_remaining_next;
            held_type_reg      <= held_type_next;
            as_acc_reg         <= as_acc_next;
            as_done_reg        <= as_done_next;
        end
    end

    // a completed AS number always leaves the scan in its ended phase
    a_done_ended: assert property (@(posedge aclk) disable iff (!aresetn)
        as_done_reg |-> phase_reg == PH_ENDED)
        else $error("as number done but scan not ended");

    // the byte counter never passes its saturation point
    a_bytes_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        bytes_seen_reg <= BYTES_SAT)
        else $error("byte counter past saturation");

    // the phase register only ever holds a defined phase
    a_phase_known: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= PH_ENDED)
        else $error("phase register holds an unused code");

endmodule
